>>> rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// Keyword token lexer package
// Shared types, token kind codes, character codes and the keyword table
// used by the front end, the token queue and the back end.
// ----------------------------------------------------------------------------
package kwl_pkg;

  // Default number of characters kept in a word or a number.
  localparam int unsigned MAX_NAME_CHARS_DEF = 16;

  // Word buffer geometry.
  localparam int unsigned BUF_DEPTH = 16;
  localparam int unsigned BUF_IDX_W = 4;
  localparam int unsigned LEN_W     = 5;

  // Token queue geometry.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef logic [4:0]                   kind_t;
  typedef logic [7:0]                   char_t;
  typedef logic [BUF_DEPTH-1:0][7:0]    word_t;
  typedef logic [LEN_W-1:0]             len_t;

  // Token kind codes.
  localparam int unsigned NUM_KEYWORDS = 19;
  localparam kind_t KIND_IDENT  = 5'd19;
  localparam kind_t KIND_NUMBER = 5'd20;
  localparam kind_t KIND_ASSIGN = 5'd21;
  localparam kind_t KIND_NOTEQ  = 5'd22;
  localparam kind_t KIND_LESSEQ = 5'd23;
  localparam kind_t KIND_MOREEQ = 5'd24;
  localparam kind_t KIND_CHAR   = 5'd25;

  // Character codes.
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_COLON = 8'h3A;
  localparam char_t CH_LESS  = 8'h3C;
  localparam char_t CH_EQUAL = 8'h3D;
  localparam char_t CH_MORE  = 8'h3E;

  // Keyword table. Text is right-aligned, so the first character of a
  // keyword of length L sits in byte L-1.
  localparam int unsigned KW_MAX_LEN = 9;
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    72'("AND"), 72'("BEGIN"), 72'("BOOLEAN"), 72'("DO"), 72'("END"),
    72'("ENDIF"), 72'("ENDWHILE"), 72'("FALSE"), 72'("IF"), 72'("IFF"),
    72'("INTEGER"), 72'("MOD"), 72'("NOT"), 72'("OR"), 72'("PROCEDURE"),
    72'("THEN"), 72'("TRUE"), 72'("WHILE"), 72'("WRITE")
  };
  localparam int unsigned KW_LEN [NUM_KEYWORDS] = '{
    3, 5, 7, 2, 3, 5, 8, 5, 2, 3, 7, 3, 3, 2, 9, 4, 4, 5, 5
  };

  // One queue entry: everything one character gives. Token A is the token
  // that a pending word, number or operator closes; token B is the
  // single-character token that the character itself may give.
  typedef struct packed {
    logic         a_valid;
    kind_t        a_kind;
    char_t        a_char;
    logic [31:0]  acc;
    logic         neg;
    word_t        word;
    len_t         len;
    logic         b_valid;
    char_t        b_char;
    logic [15:0]  line;
  } entry_t;

  // Result of a keyword lookup.
  typedef struct packed {
    logic   hit;
    kind_t  idx;
  } kw_res_t;

  // Parallel compare of a word against all keywords.
  function automatic kw_res_t kw_lookup(input word_t w, input len_t len);
    kw_res_t     r;
    logic        eq;
    int unsigned k;
    int unsigned i;
    r = '0;
    for (k = 0; k < NUM_KEYWORDS; k++) begin
      eq = (len == LEN_W'(KW_LEN[k]));
      for (i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KW_LEN[k]) begin
          if (w[i] != KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]) begin
            eq = 1'b0;
          end
        end
      end
      if (eq && !r.hit) begin
        r.hit = 1'b1;
        r.idx = kind_t'(k);
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/kwl_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one source character per beat.
// ----------------------------------------------------------------------------
interface kwl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

>>> rtl/kwl_token_if.sv
// ----------------------------------------------------------------------------
// Token channel
// Valid/ready channel that carries one token per beat.
// ----------------------------------------------------------------------------
interface kwl_token_if;
  logic               valid;
  logic               ready;
  logic [4:0]         token_kind;
  logic [7:0]         single_char;
  logic signed [31:0] number_value;
  logic [63:0]        name_chars_low;
  logic [63:0]        name_chars_high;
  logic [4:0]         name_length;
  logic [15:0]        line_number;
  logic               last_of_run;

  modport source (
    output valid, output token_kind, output single_char, output number_value,
    output name_chars_low, output name_chars_high, output name_length,
    output line_number, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input single_char, input number_value,
    input name_chars_low, input name_chars_high, input name_length,
    input line_number, input last_of_run, output ready
  );
endinterface

>>> rtl/keyword_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// Keyword token lexer
// Character stream in, token stream out. The input channel char_i takes one
// ASCII character per beat; the output channel token_o gives one token per
// beat with its kind, character, number value, identifier text, line number
// and a flag on the last token that a character gives.
// A character is accepted every cycle while the two-entry token queue has
// room. A token passes through the queue and the output register after the
// character that closes it; the two tokens of one character leave in turn,
// so with ready held high the sustained rate is one character per cycle when
// each character gives at most one token, and one token per cycle otherwise.
// A pending word, number or operator is held until the character that ends
// it arrives; there is no end-of-stream flush.
// Reset puts the scanner between tokens, the line count at one and both
// queue and output register empty. When the receiver holds ready low the
// output register keeps its beat, the queue fills, and char_i.ready drops;
// nothing is lost.
// ----------------------------------------------------------------------------
module keyword_token_lexer_unit #(
  parameter int unsigned MAX_NAME_CHARS = kwl_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwl_char_if.sink     char_i,
  kwl_token_if.source  token_o
);
  import kwl_pkg::*;

  logic    push;
  logic    room;
  logic    pop;
  logic    head_valid;
  entry_t  entry;
  entry_t  head;

  // Scanner.
  kwl_front #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_i),
    .room_i  (room),
    .push_o  (push),
    .entry_o (entry)
  );

  // Decoupling queue.
  kwl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .room_o       (room),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Token formatter and output register.
  kwl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .token_o      (token_o)
  );

endmodule

>>> rtl/kwl_front.sv
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts one character per beat, runs the scanner state machine, collects
// word characters and number digits, counts lines and pushes one queue
// entry for every character that closes or forms a token.
// ----------------------------------------------------------------------------
module kwl_front #(
  parameter int unsigned MAX_NAME_CHARS = kwl_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  kwl_char_if.sink         char_i,
  input  logic             room_i,
  output logic             push_o,
  output kwl_pkg::entry_t  entry_o
);
  import kwl_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_MINUS,
    MODE_LESS,
    MODE_MORE,
    MODE_COLON,
    MODE_WORD,
    MODE_NUMBER
  } mode_e;

  localparam len_t MaxLen  = LEN_W'(MAX_NAME_CHARS);
  localparam logic KeepTwo = (MAX_NAME_CHARS > 1);

  mode_e        mode_q, mode_d;
  len_t         len_q, len_d;
  logic [31:0]  acc_q, acc_d;
  logic         neg_q, neg_d;
  logic [15:0]  line_q, line_d;
  word_t        word_q, word_d;
  entry_t       ent;
  logic         accept;
  logic         restart;
  char_t        c;
  logic         c_space, c_alpha, c_digit;
  logic [31:0]  digit;

  // Character classes.
  assign c       = char_i.char_code;
  assign c_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign c_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  assign c_digit = (c >= 8'h30) && (c <= 8'h39);
  assign digit   = 32'(c[3:0]);

  assign char_i.ready = room_i;
  assign accept       = char_i.valid && room_i;

  // Scanner next state and queue entry.
  always_comb begin
    mode_d  = mode_q;
    len_d   = len_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    line_d  = line_q;
    word_d  = word_q;
    restart = 1'b0;

    ent         = '0;
    ent.a_kind  = KIND_CHAR;
    ent.word    = word_q;
    ent.len     = len_q;
    ent.acc     = acc_q;
    ent.neg     = neg_q;
    ent.b_char  = c;
    ent.line    = line_q + {15'b0, (c == CH_LF)};

    if (accept) begin
      line_d = ent.line;
      case (mode_q)
        MODE_MINUS: begin
          if (c_alpha) begin
            word_d[0] = CH_MINUS;
            if (KeepTwo) begin
              word_d[1] = c;
            end
            len_d  = KeepTwo ? LEN_W'(2) : LEN_W'(1);
            mode_d = MODE_WORD;
          end else if (c_digit) begin
            neg_d  = 1'b1;
            acc_d  = KeepTwo ? digit : '0;
            len_d  = KeepTwo ? LEN_W'(2) : LEN_W'(1);
            mode_d = MODE_NUMBER;
          end else begin
            ent.a_valid = 1'b1;
            ent.a_char  = CH_MINUS;
            restart     = 1'b1;
          end
        end
        MODE_LESS: begin
          if (c == CH_MORE) begin
            ent.a_valid = 1'b1;
            ent.a_kind  = KIND_NOTEQ;
            mode_d      = MODE_IDLE;
          end else if (c == CH_EQUAL) begin
            ent.a_valid = 1'b1;
            ent.a_kind  = KIND_LESSEQ;
            mode_d      = MODE_IDLE;
          end else begin
            ent.a_valid = 1'b1;
            ent.a_char  = CH_LESS;
            restart     = 1'b1;
          end
        end
        MODE_MORE: begin
          ent.a_valid = 1'b1;
          if (c == CH_EQUAL) begin
            ent.a_kind = KIND_MOREEQ;
            mode_d     = MODE_IDLE;
          end else begin
            ent.a_char = CH_MORE;
            restart    = 1'b1;
          end
        end
        MODE_COLON: begin
          ent.a_valid = 1'b1;
          if (c == CH_EQUAL) begin
            ent.a_kind = KIND_ASSIGN;
            mode_d     = MODE_IDLE;
          end else begin
            ent.a_char = CH_COLON;
            restart    = 1'b1;
          end
        end
        MODE_WORD: begin
          if (c_alpha || c_digit || (c == CH_MINUS)) begin
            if (len_q < MaxLen) begin
              word_d[len_q[BUF_IDX_W-1:0]] = c;
              len_d = len_q + LEN_W'(1);
            end
          end else begin
            ent.a_valid = 1'b1;
            ent.a_kind  = KIND_IDENT;
            restart     = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (c_digit) begin
            if (len_q < MaxLen) begin
              acc_d = (acc_q << 3) + (acc_q << 1) + digit;
              len_d = len_q + LEN_W'(1);
            end
          end else begin
            ent.a_valid = 1'b1;
            ent.a_kind  = KIND_NUMBER;
            restart     = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase

      // Start of a new token with the current character.
      if (restart) begin
        mode_d = MODE_IDLE;
        if (c_space) begin
          mode_d = MODE_IDLE;
        end else if (c == CH_MINUS) begin
          mode_d = MODE_MINUS;
        end else if (c == CH_LESS) begin
          mode_d = MODE_LESS;
        end else if (c == CH_MORE) begin
          mode_d = MODE_MORE;
        end else if (c == CH_COLON) begin
          mode_d = MODE_COLON;
        end else if (c_alpha) begin
          word_d[0] = c;
          len_d     = LEN_W'(1);
          mode_d    = MODE_WORD;
        end else if (c_digit) begin
          acc_d  = digit;
          neg_d  = 1'b0;
          len_d  = LEN_W'(1);
          mode_d = MODE_NUMBER;
        end else begin
          ent.b_valid = 1'b1;
        end
      end
    end
  end

  assign push_o  = accept && (ent.a_valid || ent.b_valid);
  assign entry_o = ent;

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      len_q  <= '0;
      acc_q  <= '0;
      neg_q  <= 1'b0;
      line_q <= 16'd1;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      line_q <= line_d;
    end
  end

  // Word buffer; only entries below the length are ever read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

>>> rtl/kwl_queue.sv
// ----------------------------------------------------------------------------
// Token queue
// Two-entry queue between the front end and the back end, so that a stall
// on one side does not at once hold up the other.
// ----------------------------------------------------------------------------
module kwl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kwl_pkg::entry_t  entry_i,
  output logic             room_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output kwl_pkg::entry_t  head_o
);
  import kwl_pkg::*;

  entry_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]    count_q;

  assign room_o       = (count_q != QCNT_W'(QDEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/kwl_back.sv
// ----------------------------------------------------------------------------
// Lexer back end
// Takes queue entries, resolves keywords, packs identifier characters and
// signs numbers, and drives up to two token beats per entry through the
// output register.
// ----------------------------------------------------------------------------
module kwl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  kwl_pkg::entry_t  head_i,
  output logic             pop_o,
  kwl_token_if.source      token_o
);
  import kwl_pkg::*;

  logic               sub_q, sub_d;
  logic               out_valid_q, out_valid_d;
  logic               load;
  logic               use_a;
  logic               last;
  kw_res_t            kw;
  word_t              masked;

  kind_t              kind_d, kind_q;
  char_t              char_d, char_q;
  logic signed [31:0] num_d, num_q;
  logic [63:0]        lo_d, lo_q, hi_d, hi_q;
  len_t               len_d, len_q;
  logic [15:0]        line_q;
  logic               last_q;

  assign load  = head_valid_i && (!out_valid_q || token_o.ready);
  assign use_a = head_i.a_valid && !sub_q;
  assign last  = use_a ? !head_i.b_valid : 1'b1;
  assign pop_o = load && last;

  // Keyword compare and identifier packing.
  assign kw = kw_lookup(head_i.word, head_i.len);
  always_comb begin
    for (int i = 0; i < BUF_DEPTH; i++) begin
      masked[i] = (LEN_W'(i) < head_i.len) ? head_i.word[i] : 8'h00;
    end
  end

  // Token fields for the beat being loaded.
  always_comb begin
    kind_d = KIND_CHAR;
    char_d = head_i.b_char;
    num_d  = '0;
    lo_d   = '0;
    hi_d   = '0;
    len_d  = '0;
    if (use_a) begin
      kind_d = head_i.a_kind;
      char_d = '0;
      case (head_i.a_kind)
        KIND_CHAR: begin
          char_d = head_i.a_char;
        end
        KIND_NUMBER: begin
          num_d = head_i.neg ? -$signed(head_i.acc) : $signed(head_i.acc);
        end
        KIND_IDENT: begin
          if (kw.hit) begin
            kind_d = kw.idx;
          end else begin
            lo_d  = masked[7:0];
            hi_d  = masked[15:8];
            len_d = head_i.len;
          end
        end
        default: begin
          char_d = '0;
        end
      endcase
    end
  end

  // Beat sequencing within an entry and output valid.
  always_comb begin
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    if (token_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      sub_d       = use_a && head_i.b_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      char_q <= char_d;
      num_q  <= num_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      len_q  <= len_d;
      line_q <= head_i.line;
      last_q <= last;
    end
  end

  assign token_o.valid           = out_valid_q;
  assign token_o.token_kind      = kind_q;
  assign token_o.single_char     = char_q;
  assign token_o.number_value    = num_q;
  assign token_o.name_chars_low  = lo_q;
  assign token_o.name_chars_high = hi_q;
  assign token_o.name_length     = len_q;
  assign token_o.line_number     = line_q;
  assign token_o.last_of_run     = last_q;

endmodule
